FILE: rtl/bbpa_pkg.sv
// Shared types and constants for the bitmap buffer pool allocator.
// Holds the request and result structs, status codes and register indexes.
// No dependencies.
package bbpa_pkg;

	localparam int MAX_BUFFERS = 256;
	localparam int WORD_BITS   = 32;
	localparam int WORD_COUNT  = (MAX_BUFFERS + WORD_BITS - 1) / WORD_BITS;
	localparam int IDX_W       = $clog2(MAX_BUFFERS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int WSEL_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BSEL_W      = $clog2(WORD_BITS);

	localparam int ADDR_W      = 32;
	localparam int SIZE_W      = 21;
	localparam int LIMIT_W     = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

	localparam logic [1:0] ST_OK            = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED     = 2'd1;
	localparam logic [1:0] ST_RANGE         = 2'd2;
	localparam logic [1:0] ST_NOT_ALLOCATED = 2'd3;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] buffer_address;
		logic [7:0]        buffer_index;
		logic [8:0]        allocated_count;
	} rsp_t;

endpackage

FILE: rtl/bitmap_buffer_pool_allocator_top.sv
// Allocate: scans one 32-bit bitmap word per cycle up to the first free bit below the
// limit, then multiplies and adds; exhausted without a scan when the count is at the limit.
// Free: a range check, then the restoring divider that resolves one quotient bit per
// cycle, skipped when the address is out of range. One request is processed at a time;
// a new request is taken while a result still waits. Asynchronous active-low reset clears
// the used bitmap and count, and sets default configuration. Top level; depends on bbpa_pkg.
module bitmap_buffer_pool_allocator_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  bbpa_pkg::req_t                         in_item,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output bbpa_pkg::rsp_t                         out_item,
	input  logic                                   cfg_we,
	input  logic [bbpa_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bbpa_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ASCAN = 3'd1;
	localparam logic [2:0] S_AMUL  = 3'd2;
	localparam logic [2:0] S_AADD  = 3'd3;
	localparam logic [2:0] S_FCHK  = 3'd4;
	localparam logic [2:0] S_FDIV  = 3'd5;
	localparam logic [2:0] S_FBIT  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	localparam int SPAN_W = bbpa_pkg::SIZE_W + bbpa_pkg::LIMIT_W;
	localparam int PROD_W = bbpa_pkg::SIZE_W + bbpa_pkg::IDX_W;

	logic [2:0]                                   state_q;
	logic [bbpa_pkg::ADDR_W-1:0]                  base_q;
	logic [bbpa_pkg::SIZE_W-1:0]                  size_q;
	logic [bbpa_pkg::LIMIT_W-1:0]                 limit_q;
	logic [bbpa_pkg::MAX_BUFFERS-1:0]             used_q;
	logic [bbpa_pkg::CNT_W-1:0]                   count_q;
	logic [bbpa_pkg::WSEL_W-1:0]                  word_q;
	logic [bbpa_pkg::IDX_W-1:0]                   idx_q;
	logic [bbpa_pkg::IDX_W-1:0]                   quot_q;
	logic [$clog2(bbpa_pkg::IDX_W)-1:0]           step_q;
	logic [bbpa_pkg::ADDR_W-1:0]                  rem_q;
	logic                                         ge_base_q;
	logic [SPAN_W-1:0]                            span_q;
	logic [PROD_W-1:0]                            prod_q;
	logic [1:0]                                   status_q;
	logic [bbpa_pkg::ADDR_W-1:0]                  res_addr_q;
	logic                                         out_valid_q;
	bbpa_pkg::rsp_t                               out_item_q;

	logic [bbpa_pkg::LIMIT_W-1:0]                 lim_eff;
	logic [bbpa_pkg::WORD_BITS-1:0]               word_bits;
	logic [bbpa_pkg::WORD_BITS-1:0]               below_lim;
	logic [bbpa_pkg::WORD_BITS-1:0]               cand;
	logic [bbpa_pkg::WORD_BITS-1:0]               lowest;
	logic [bbpa_pkg::BSEL_W-1:0]                  pos;
	logic [PROD_W-1:0]                            div_trial;
	logic                                         accept;
	logic                                         out_load;

	assign lim_eff = (limit_q > bbpa_pkg::LIMIT_W'(bbpa_pkg::MAX_BUFFERS))
		? bbpa_pkg::LIMIT_W'(bbpa_pkg::MAX_BUFFERS) : limit_q;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Free bits of the current word that lie below the effective limit.
	always_comb begin
		word_bits = used_q[word_q*bbpa_pkg::WORD_BITS +: bbpa_pkg::WORD_BITS];
		for (int j = 0; j < bbpa_pkg::WORD_BITS; j++) begin
			below_lim[j] = ({1'b0, word_q, bbpa_pkg::BSEL_W'(j)} < lim_eff);
		end
		cand   = ~word_bits & below_lim;
		lowest = cand & (~cand + 1'b1);
		pos    = '0;
		for (int j = 0; j < bbpa_pkg::WORD_BITS; j++) begin
			if (lowest[j]) begin
				pos = pos | bbpa_pkg::BSEL_W'(j);
			end
		end
	end

	assign div_trial = {size_q, bbpa_pkg::IDX_W'(0)} >> (bbpa_pkg::IDX_W - int'(step_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			size_q  <= bbpa_pkg::SIZE_W'(4096);
			limit_q <= bbpa_pkg::LIMIT_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bbpa_pkg::REG_BASE:  base_q  <= cfg_wdata;
				bbpa_pkg::REG_SIZE:  size_q  <= cfg_wdata[bbpa_pkg::SIZE_W-1:0];
				bbpa_pkg::REG_LIMIT: limit_q <= cfg_wdata[bbpa_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_item.mode == bbpa_pkg::MODE_ALLOC) begin
							state_q <= ({1'b0, count_q} >= {1'b0, lim_eff}) ? S_DONE : S_ASCAN;
						end else begin
							state_q <= S_FCHK;
						end
					end
				end
				S_ASCAN: begin
					if (cand != '0) begin
						state_q <= S_AMUL;
					end else if (word_q == bbpa_pkg::WSEL_W'(bbpa_pkg::WORD_COUNT - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_AMUL: state_q <= S_AADD;
				S_AADD: begin
					used_q[idx_q] <= 1'b1;
					count_q       <= count_q + 1'b1;
					state_q       <= S_DONE;
				end
				S_FCHK: begin
					if (!ge_base_q || {2'b0, rem_q} >= {{(bbpa_pkg::ADDR_W + 2 - SPAN_W){1'b0}}, span_q}) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_FDIV;
					end
				end
				S_FDIV: begin
					if (step_q == '0) begin
						state_q <= S_FBIT;
					end
				end
				S_FBIT: begin
					if (used_q[quot_q]) begin
						used_q[quot_q] <= 1'b0;
						if (count_q != '0) begin
							count_q <= count_q - 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_q   <= (in_item.mode == bbpa_pkg::MODE_ALLOC) ? bbpa_pkg::ST_EXHAUSTED
						: bbpa_pkg::ST_RANGE;
					res_addr_q <= '0;
					idx_q      <= '0;
					word_q     <= '0;
					ge_base_q  <= (in_item.free_address >= base_q);
					rem_q      <= in_item.free_address - base_q;
					span_q     <= SPAN_W'(size_q) * SPAN_W'(lim_eff);
				end
			end
			S_ASCAN: begin
				if (cand != '0) begin
					idx_q <= bbpa_pkg::IDX_W'({word_q, pos});
				end else begin
					word_q <= word_q + 1'b1;
				end
			end
			S_AMUL: prod_q <= PROD_W'(idx_q) * PROD_W'(size_q);
			S_AADD: begin
				res_addr_q <= base_q + bbpa_pkg::ADDR_W'(prod_q);
				status_q   <= bbpa_pkg::ST_OK;
			end
			S_FCHK: begin
				quot_q <= '0;
				step_q <= '1;
			end
			S_FDIV: begin
				// Restoring division, one quotient bit per cycle, most significant first.
				if (rem_q >= bbpa_pkg::ADDR_W'(div_trial)) begin
					rem_q          <= rem_q - bbpa_pkg::ADDR_W'(div_trial);
					quot_q[step_q] <= 1'b1;
				end
				step_q <= step_q - 1'b1;
			end
			S_FBIT: begin
				idx_q    <= quot_q;
				status_q <= used_q[quot_q] ? bbpa_pkg::ST_OK : bbpa_pkg::ST_NOT_ALLOCATED;
			end
			S_DONE: begin
				if (out_load) begin
					out_item_q.status          <= status_q;
					out_item_q.buffer_address  <= res_addr_q;
					out_item_q.buffer_index    <= idx_q;
					out_item_q.allocated_count <= count_q;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/bbpa_checker.sv
// Port-level checks for the bitmap buffer pool allocator, bound to the top level.
// Depends on bbpa_pkg and bitmap_buffer_pool_allocator_top.
module bbpa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input bbpa_pkg::req_t in_item,
	input logic           out_valid,
	input logic           out_ready,
	input bbpa_pkg::rsp_t out_item
);

	// A result that is held back stays unchanged until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Only one request is in work at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// Only a successful allocate carries an address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != bbpa_pkg::ST_OK && out_item.buffer_address != '0 |-> 1'b0)
		else $error("address on failed request");

	a_range_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == bbpa_pkg::ST_RANGE ||
		out_item.status == bbpa_pkg::ST_EXHAUSTED) |-> out_item.buffer_index == '0)
		else $error("index on failed request");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.allocated_count <= 9'(bbpa_pkg::MAX_BUFFERS))
		else $error("count beyond pool size");

endmodule

bind bitmap_buffer_pool_allocator_top bbpa_checker u_bbpa_checker (.*);
